// ===== hw/rtl/octave_value_noise_2d_assert.svh =====
// ----------------------------------------------------------------------------
// octave_value_noise_2d_assert
// Assertion macros shared by the checkers of the octave value noise block.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_VALUE_NOISE_2D_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OVN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ovn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ovn assertion failed");

`endif

// ===== hw/rtl/ovn_pkg.sv =====
// ----------------------------------------------------------------------------
// ovn_pkg
// Types and constants shared by the octave value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

    localparam int C_GRID_LOG2 = 6;
    localparam int C_COORD_W   = 6;
    localparam int C_ADDR_W    = 2 * C_GRID_LOG2;
    localparam int C_SEED_W    = 16;
    localparam int C_BIAS_W    = 16;
    localparam int C_WGT_W     = 24;
    localparam int C_ACC_W     = 43;
    localparam int C_WSUM_W    = 27;
    localparam int C_DIV_W     = 44;
    localparam int C_QUOT_W    = 24;
    localparam int C_STEP_W    = 5;
    localparam int C_MUL_A_W   = 25;
    localparam int C_MUL_B_W   = 18;
    localparam int C_PROD_W    = C_MUL_A_W + C_MUL_B_W;

    localparam logic [C_WGT_W-1:0] C_WGT_ONE = 24'h010000;
    localparam logic [C_WGT_W-1:0] C_WGT_MAX = 24'hFFFFFF;

    localparam logic C_MODE_WRITE = 1'b0;
    localparam logic C_MODE_QUERY = 1'b1;

    localparam logic C_REG_OCTAVES = 1'b0;
    localparam logic C_REG_BIAS    = 1'b1;

    typedef struct packed {
        logic                start;
        logic [C_DIV_W-1:0]  num;
        logic [C_DIV_W-1:0]  den;
        logic [C_STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== hw/rtl/ovn_seed_ram.sv =====
// ----------------------------------------------------------------------------
// ovn_seed_ram
// Seed grid storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ovn_seed_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ovn_pkg::C_ADDR_W-1:0] i_wr_addr,
    input  logic [ovn_pkg::C_SEED_W-1:0] i_wr_data,
    input  logic [ovn_pkg::C_ADDR_W-1:0] i_rd_addr,
    output logic [ovn_pkg::C_SEED_W-1:0] o_rd_data
);
    import ovn_pkg::*;

    logic [C_SEED_W-1:0] r_mem [2**C_ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hw/rtl/ovn_mul.sv =====
// ----------------------------------------------------------------------------
// ovn_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ovn_mul (
    input  logic                                i_clk,
    input  logic signed [ovn_pkg::C_MUL_A_W-1:0] i_a,
    input  logic signed [ovn_pkg::C_MUL_B_W-1:0] i_b,
    output logic signed [ovn_pkg::C_PROD_W-1:0]  o_prod
);
    import ovn_pkg::*;

    always_ff @(posedge i_clk) begin
        o_prod <= C_PROD_W'(i_a) * C_PROD_W'(i_b);
    end

endmodule

// ===== hw/rtl/ovn_div.sv =====
// ----------------------------------------------------------------------------
// ovn_div
// Restoring divider, one quotient bit per cycle. The divisor arrives already
// aligned to the top quotient bit.
// ----------------------------------------------------------------------------
module ovn_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ovn_pkg::t_div_req            i_req,
    output logic [ovn_pkg::C_QUOT_W-1:0] o_quot,
    output logic                         o_done
);
    import ovn_pkg::*;

    logic                r_busy;
    logic [C_STEP_W-1:0] r_cnt;
    logic [C_DIV_W-1:0]  r_rem;
    logic [C_DIV_W-1:0]  r_den;
    logic                w_ge;

    assign w_ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            o_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_den;
            end
            o_quot <= {o_quot[C_QUOT_W-2:0], w_ge};
            r_den  <= r_den >> 1;
        end
    end

endmodule

// ===== hw/rtl/octave_value_noise_2d.sv =====
// A seed write is stored when it is accepted. A query runs each octave as a fetch,
// a multiply and blend and a weight division, the division being skipped after the
// last octave or once the weight saturates, and then normalizes the weighted sum.
// The block takes one request at a time, as it shares one multiplier and one divider;
// a new request waits until the last result is loaded. Synchronous active-low reset
// restores octave_count 6 and bias 8192; seed storage is not cleared.
// ----------------------------------------------------------------------------
// octave_value_noise_2d
// Multi-octave value noise over a stored seed grid.
// ----------------------------------------------------------------------------
module octave_value_noise_2d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ovn_pkg::C_BIAS_W-1:0]  i_cfg_data,
    // Request channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [ovn_pkg::C_COORD_W-1:0] i_col,
    input  logic [ovn_pkg::C_COORD_W-1:0] i_row,
    input  logic [ovn_pkg::C_SEED_W-1:0]  i_seed_value,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ovn_pkg::C_SEED_W-1:0]  o_noise_value
);
    import ovn_pkg::*;

    // Sequencer states. Each octave runs FETCH, MUL0..MUL6 and, unless it is
    // the last one or the weight has saturated, a weight division. The query
    // ends with one division.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_MUL0  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_MUL3  = 4'd5;
    localparam logic [3:0] S_MUL4  = 4'd6;
    localparam logic [3:0] S_MUL5  = 4'd7;
    localparam logic [3:0] S_MUL6  = 4'd8;
    localparam logic [3:0] S_WDIV  = 4'd9;
    localparam logic [3:0] S_WWAIT = 4'd10;
    localparam logic [3:0] S_NDIV  = 4'd11;
    localparam logic [3:0] S_NWAIT = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam int C_FRAC_SH = 16 - C_GRID_LOG2;

    logic [3:0]             r_state, n_state;
    logic [2:0]             r_k;
    logic [2:0]             r_oct;
    logic [2:0]             r_last;
    logic [2:0]             r_octave_count;
    logic [C_BIAS_W-1:0]    r_bias;
    logic [C_BIAS_W-1:0]    r_bias_eff;
    logic [C_COORD_W-1:0]   r_x, r_y;
    logic [C_SEED_W-1:0]    r_seed [4];
    logic [C_SEED_W-1:0]    r_top, r_bot, r_v;
    logic [C_WGT_W-1:0]     r_w;
    logic [C_ACC_W-1:0]     r_acc;
    logic [C_WSUM_W-1:0]    r_wsum;
    logic                   r_out_valid;
    logic [C_SEED_W-1:0]    r_noise;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic [C_COORD_W-1:0]   w_mask, w_x1, w_x2, w_y1, w_y2;
    logic [C_SEED_W-1:0]    w_bx, w_by;
    logic [C_ADDR_W-1:0]    w_rd_addr;
    logic [C_SEED_W-1:0]    w_rd_data;
    logic signed [C_MUL_A_W-1:0] w_mul_a;
    logic signed [C_MUL_B_W-1:0] w_mul_b;
    logic signed [C_PROD_W-1:0]  w_prod;
    logic [C_SEED_W-1:0]    w_lerp;
    t_div_req               w_div_req;
    logic [C_QUOT_W-1:0]    w_quot;
    logic                   w_div_done;
    logic [2:0]             w_n;

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;
    assign w_out_free    = !r_out_valid || !i_out_stall;

    // Cell corners on the current pitch. The pitch is a power of two, so the
    // cell origin is a mask and the blend fraction a shift of the offset.
    assign w_mask = C_COORD_W'({C_COORD_W{1'b1}} >> r_oct);
    assign w_x1   = r_x & ~w_mask;
    assign w_y1   = r_y & ~w_mask;
    assign w_x2   = C_COORD_W'((C_COORD_W + 1)'(w_x1) +
                    ((C_COORD_W + 1)'(1) << (C_GRID_LOG2 - 32'(r_oct))));
    assign w_y2   = C_COORD_W'((C_COORD_W + 1)'(w_y1) +
                    ((C_COORD_W + 1)'(1) << (C_GRID_LOG2 - 32'(r_oct))));
    assign w_bx   = C_SEED_W'(C_SEED_W'(r_x & w_mask) << (C_FRAC_SH + 32'(r_oct)));
    assign w_by   = C_SEED_W'(C_SEED_W'(r_y & w_mask) << (C_FRAC_SH + 32'(r_oct)));

    always_comb begin
        case (r_k)
            3'd0:    w_rd_addr = {w_y1, w_x1};
            3'd1:    w_rd_addr = {w_y1, w_x2};
            3'd2:    w_rd_addr = {w_y2, w_x1};
            default: w_rd_addr = {w_y2, w_x2};
        endcase
    end

    ovn_seed_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (w_in_acc && (i_mode == C_MODE_WRITE)),
        .i_wr_addr ({i_row, i_col}),
        .i_wr_data (i_seed_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // A blend is a + f*(b - a) / 65536, floored; the multiplier forms f*(b - a).
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL0: begin
                w_mul_a = C_MUL_A_W'($signed({1'b0, r_seed[1]}) - $signed({1'b0, r_seed[0]}));
                w_mul_b = $signed({2'b00, w_bx});
            end
            S_MUL1: begin
                w_mul_a = C_MUL_A_W'($signed({1'b0, r_seed[3]}) - $signed({1'b0, r_seed[2]}));
                w_mul_b = $signed({2'b00, w_bx});
            end
            S_MUL3: begin
                w_mul_a = C_MUL_A_W'($signed({1'b0, r_bot}) - $signed({1'b0, r_top}));
                w_mul_b = $signed({2'b00, w_by});
            end
            S_MUL5: begin
                w_mul_a = $signed({1'b0, r_w});
                w_mul_b = $signed({2'b00, r_v});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    ovn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Base of the blend that the product belongs to, plus the scaled difference.
    always_comb begin
        case (r_state)
            S_MUL1:  w_lerp = C_SEED_W'({2'b00, r_seed[0]} + w_prod[33:16]);
            S_MUL2:  w_lerp = C_SEED_W'({2'b00, r_seed[2]} + w_prod[33:16]);
            default: w_lerp = C_SEED_W'({2'b00, r_top} + w_prod[33:16]);
        endcase
    end

    always_comb begin
        w_div_req = '0;
        case (r_state)
            S_WDIV: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = C_DIV_W'(r_w) << 12;
                w_div_req.den   = C_DIV_W'(r_bias_eff) << (C_QUOT_W - 1);
                w_div_req.steps = C_STEP_W'(C_QUOT_W);
            end
            S_NDIV: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = C_DIV_W'(r_acc);
                w_div_req.den   = C_DIV_W'(r_wsum) << (C_SEED_W - 1);
                w_div_req.steps = C_STEP_W'(C_SEED_W);
            end
            default: w_div_req = '0;
        endcase
    end

    ovn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // Octave count as used: zero counts as one, and it never exceeds the
    // number of times the grid size halves.
    always_comb begin
        if (r_octave_count == 3'd0) begin
            w_n = 3'd1;
        end else if (32'(r_octave_count) > C_GRID_LOG2) begin
            w_n = 3'(C_GRID_LOG2);
        end else begin
            w_n = r_octave_count;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc && (i_mode == C_MODE_QUERY)) n_state = S_FETCH;
            S_FETCH: if (r_k == 3'd4) n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_MUL4;
            S_MUL4:  n_state = S_MUL5;
            S_MUL5:  n_state = S_MUL6;
            S_MUL6: begin
                if (r_oct == r_last) begin
                    n_state = S_NDIV;
                end else if (28'(r_w) >= {r_bias_eff, 12'h000}) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_WDIV;
                end
            end
            S_WDIV:  n_state = S_WWAIT;
            S_WWAIT: if (w_div_done) n_state = S_FETCH;
            S_NDIV:  n_state = S_NWAIT;
            S_NWAIT: if (w_div_done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_k            <= '0;
            r_oct          <= '0;
            r_last         <= '0;
            r_octave_count <= 3'd6;
            r_bias         <= 16'd8192;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == C_REG_OCTAVES) begin
                    r_octave_count <= i_cfg_data[2:0];
                end else begin
                    r_bias <= i_cfg_data;
                end
            end
            // A result is loaded once the previous one has been taken, and it
            // stays valid for as long as the receiver stalls it.
            r_out_valid <= ((r_state == S_DONE) && w_out_free) ||
                           (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    r_k    <= '0;
                    r_oct  <= '0;
                    r_last <= w_n - 3'd1;
                end
                S_FETCH: begin
                    if (r_k != 3'd4) begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_MUL6: begin
                    r_k <= '0;
                    if (r_oct != r_last && 28'(r_w) >= {r_bias_eff, 12'h000}) begin
                        r_oct <= r_oct + 3'd1;
                    end
                end
                S_WWAIT: begin
                    if (w_div_done) begin
                        r_oct <= r_oct + 3'd1;
                    end
                end
                default: r_k <= r_k;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x        <= i_col;
                r_y        <= i_row;
                r_bias_eff <= (r_bias == '0) ? C_BIAS_W'(1) : r_bias;
                r_w        <= C_WGT_ONE;
                r_acc      <= '0;
                r_wsum     <= '0;
            end
            S_FETCH: begin
                if (r_k != 3'd0) begin
                    r_seed[2'(r_k - 3'd1)] <= w_rd_data;
                end
            end
            S_MUL1:  r_top <= w_lerp;
            S_MUL2:  r_bot <= w_lerp;
            S_MUL4:  r_v   <= w_lerp;
            S_MUL6: begin
                r_acc  <= r_acc + C_ACC_W'(w_prod[39:0]);
                r_wsum <= r_wsum + C_WSUM_W'(r_w);
                if (28'(r_w) >= {r_bias_eff, 12'h000}) begin
                    r_w <= C_WGT_MAX;
                end
            end
            S_WWAIT: begin
                if (w_div_done) begin
                    r_w <= w_quot;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_noise <= w_quot[C_SEED_W-1:0];
                end
            end
            default: r_v <= r_v;
        endcase
    end

endmodule

// ===== hw/rtl/ovn_checker.sv =====
// ----------------------------------------------------------------------------
// ovn_checker
// Port-level checks of the octave value noise block, bound to the top level.
// ----------------------------------------------------------------------------
`include "octave_value_noise_2d_assert.svh"

module ovn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_mode,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ovn_pkg::C_SEED_W-1:0]  o_noise_value
);
    import ovn_pkg::*;

    // A waiting result holds until it is taken.
    `OVN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_noise_value))

    // An accepted query keeps the block busy on the following cycle.
    `OVN_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_mode == C_MODE_QUERY), o_in_stall)

    // A seed write never produces a result.
    `OVN_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_mode == C_MODE_WRITE) && !o_out_valid,
        !o_out_valid)

    // The block only takes new requests while its sequencer is idle, so no
    // new result can appear right after a request is accepted.
    `OVN_ASSERT_NEXT(a_no_result_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, !$rose(o_out_valid))

    // The user must write registers only while nothing is in flight; the block does not enforce it.
    `OVN_ASSERT_NOW(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, !o_in_stall && !o_out_valid)

endmodule

bind octave_value_noise_2d ovn_checker u_ovn_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the octave value noise block. Requests are driven through
// the valid/stall request channel, each accepted query is predicted by a
// bit-accurate model of the octave blend, and every result is compared with
// the oldest prediction. Configuration changes happen only while idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ovn_pkg::*;

    localparam int GRID      = 64;
    localparam int MAX_OCT   = 6;
    localparam int DRAIN_CYC = 300;
    localparam int WATCHDOG  = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [C_BIAS_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_mode;
    logic [C_COORD_W-1:0] req_col;
    logic [C_COORD_W-1:0] req_row;
    logic [C_SEED_W-1:0]  req_seed;
    logic                 out_valid;
    logic                 out_stall;
    logic [C_SEED_W-1:0]  noise_value;

    // Mirror of the block's state used for prediction.
    logic [C_SEED_W-1:0]  seed_mirror [GRID*GRID];
    logic [2:0]           octaves_reg;
    logic [C_BIAS_W-1:0]  bias_reg;

    logic [C_SEED_W-1:0]  noise_expected [$];
    int                   mismatches;
    int                   idle_cycles;
    bit                   calm_stretch;
    bit                   timed_out;

    octave_value_noise_2d uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_mode       (req_mode),
        .i_col        (req_col),
        .i_row        (req_row),
        .i_seed_value (req_seed),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_noise_value(noise_value)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Bilinear step in Q0.16 with truncation.
    function automatic logic [31:0] blend_q16(logic [31:0] a, logic [31:0] b,
                                              logic [31:0] f);
        logic [63:0] s;
        s = (64'd65536 - f) * a + 64'(f) * b;
        return s[47:16];
    endfunction

    // Weighted sum of the octave layers at one point, normalized by the weights.
    function automatic logic [C_SEED_W-1:0] octave_noise(int x, int y);
        int          n;
        int          pitch, x1, y1, x2, y2;
        logic [31:0] bdiv, bx, by, top, bot, v;
        logic [63:0] w, acc, wsum;
        n = (octaves_reg == 3'd0) ? 1 : int'(octaves_reg);
        if (n > MAX_OCT) begin
            n = MAX_OCT;
        end
        bdiv = (bias_reg == '0) ? 32'd1 : 32'(bias_reg);
        w    = 64'd65536;
        acc  = 0;
        wsum = 0;
        for (int o = 0; o < n; o++) begin
            pitch = GRID >> o;
            x1 = (x / pitch) * pitch;
            y1 = (y / pitch) * pitch;
            x2 = (x1 + pitch) % GRID;
            y2 = (y1 + pitch) % GRID;
            bx = ((x - x1) << 16) / pitch;
            by = ((y - y1) << 16) / pitch;
            top = blend_q16(32'(seed_mirror[y1*GRID+x1]), 32'(seed_mirror[y1*GRID+x2]), bx);
            bot = blend_q16(32'(seed_mirror[y2*GRID+x1]), 32'(seed_mirror[y2*GRID+x2]), bx);
            v = blend_q16(top, bot, by);
            acc  += 64'(v) * w;
            wsum += w;
            w = (w << 12) / 64'(bdiv);
            if (w > 64'hFFFFFF) begin
                w = 64'hFFFFFF;
            end
        end
        return C_SEED_W'(acc / wsum);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Random gaps on both channels, except during a calm stretch.
    function automatic bit random_gap();
        return !calm_stretch && ($urandom_range(99) < 21);
    endfunction

    // Sends one request; the model updates when the request is accepted.
    // Valid stays high on return so that the next request can follow at once.
    task automatic send_request(logic mode, int col, int row, int seed);
        if (random_gap()) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (random_gap()) begin
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        req_mode <= mode;
        req_col  <= C_COORD_W'(col);
        req_row  <= C_COORD_W'(row);
        req_seed <= C_SEED_W'(seed);
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (mode == C_MODE_WRITE) begin
            seed_mirror[row*GRID+col] = C_SEED_W'(seed);
        end else begin
            noise_expected.push_back(octave_noise(col, row));
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (noise_expected.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic write_register(logic index, int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= C_BIAS_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == C_REG_OCTAVES) begin
            octaves_reg = 3'(value);
        end else begin
            bias_reg = C_BIAS_W'(value);
        end
    endtask

    // Corners always fall on even rows and columns, so those are the entries
    // that a query can read.
    task automatic fill_grid();
        for (int r = 0; r < GRID; r += 2) begin
            for (int c = 0; c < GRID; c += 2) begin
                send_request(C_MODE_WRITE, c, r, $urandom_range(65535));
            end
        end
    endtask

    // Directed queries at the grid corners, edges and cell midpoints.
    task automatic test_directed();
        send_request(C_MODE_WRITE, 0, 0, 16'hFFFF);
        send_request(C_MODE_WRITE, 63, 63, 16'h0000);
        send_request(C_MODE_QUERY, 0, 0, 0);
        send_request(C_MODE_QUERY, 63, 63, 16'hFFFF);
        send_request(C_MODE_QUERY, 63, 0, 0);
        send_request(C_MODE_QUERY, 0, 63, 0);
        send_request(C_MODE_QUERY, 32, 32, 0);
        send_request(C_MODE_QUERY, 21, 42, 0);
        send_request(C_MODE_QUERY, 1, 1, 0);
    endtask

    // Octave count and bias extremes, including zero values.
    task automatic test_registers();
        int octave_set [5] = '{0, 1, 3, 6, 7};
        int bias_set [6]   = '{0, 1, 256, 4096, 65535, 8192};
        foreach (bias_set[b]) begin
            write_register(C_REG_BIAS, bias_set[b]);
            foreach (octave_set[o]) begin
                write_register(C_REG_OCTAVES, octave_set[o]);
                repeat (3) begin
                    send_request(C_MODE_QUERY, $urandom_range(63),
                                 $urandom_range(63), $urandom_range(65535));
                end
            end
        end
    endtask

    // Mixed writes and queries with random content and configurations.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                write_register(C_REG_OCTAVES, $urandom_range(7));
                write_register(C_REG_BIAS, $urandom_range(65535));
            end
            calm_stretch = (i >= 60 && i < 140);
            send_request($urandom_range(2) != 0, $urandom_range(63),
                         $urandom_range(63), $urandom_range(65535));
        end
        calm_stretch = 1'b0;
    endtask

    // The sender holds off until the block has drained completely.
    task automatic test_hold_off();
        send_request(C_MODE_QUERY, 17, 45, 0);
        wait_idle();
        send_request(C_MODE_QUERY, 45, 17, 0);
    endtask

    // Result checker and stall generator on the result channel.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (noise_expected.size() == 0) begin
                report_mismatch("unexpected noise_value", int'(noise_value), -1);
            end else begin
                if (noise_value !== noise_expected[0]) begin
                    report_mismatch("noise_value", int'(noise_value),
                                    int'(noise_expected[0]));
                end
                void'(noise_expected.pop_front());
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= rst_n && random_gap();
    end

    // Ends the run when nothing has been accepted for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("octave_value_noise_2d: mismatch");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_mode     = 1'b0;
        req_col      = '0;
        req_row      = '0;
        req_seed     = '0;
        out_stall    = 1'b0;
        mismatches   = 0;
        calm_stretch = 1'b0;
        octaves_reg  = 3'd6;
        bias_reg     = 16'd8192;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every readable seed is written before any query.
        fill_grid();
        test_directed();
        test_registers();
        test_hold_off();
        test_random(175);

        wait_idle();
        if (mismatches == 0) begin
            $display("octave_value_noise_2d: match");
        end else begin
            $display("octave_value_noise_2d: mismatch");
        end
        $finish;
    end
endmodule
